// ----- hdl/dshot_frame_encoder_top_defines.svh -----
// Assertion macros shared by the DShot frame encoder RTL.
// Included by the top level; no other dependencies.
`ifndef DSHOT_FRAME_ENCODER_TOP_DEFINES_SVH
`define DSHOT_FRAME_ENCODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, disabled while reset is asserted.
`define DFE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dshot frame encoder check failed");
// Checked property, also evaluated during reset.
`define DFE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dshot frame encoder check failed");
`else
`define DFE_ASSERT(label, prop)
`define DFE_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- hdl/dfe_pkg.sv -----
// Shared constants, types and helpers for the DShot frame encoder.
// No dependencies; used by the interface, register, lane, serialiser and top files.
package dfe_pkg;

  // Number of motor channels encoded per item.
  localparam int CHANNELS = 4;
  localparam int FRAME_W  = 16;
  localparam int SER_W    = CHANNELS * FRAME_W;

  // Field widths.
  localparam int US_W    = 12;
  localparam int TICK_W  = 15;
  localparam int CH_W    = 2;
  localparam int BIT_W   = 4;
  localparam int VALUE_W = 11;

  // Throttle mapping constants.
  localparam logic [US_W-1:0] US_IDLE      = 12'd1000;
  localparam logic [US_W-1:0] US_BASE      = 12'd1001;
  localparam int              SPAN_MUL     = 1999;
  localparam int              PROD_W       = 23;
  // Reciprocal of 999 scaled by 2^33, rounded up; exact for products below 2^23.
  localparam int              RECIP_SHIFT  = 33;
  localparam int              RECIP_W      = 24;
  localparam logic [RECIP_W-1:0] RECIP_999 = 24'd8598534;
  localparam int              QUOT_W       = 13;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 11'd48;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 11'd2047;

  // Register map (index into the register list).
  localparam logic [1:0] REG_ZERO_HIGH = 2'd0;
  localparam logic [1:0] REG_ZERO_LOW  = 2'd1;
  localparam logic [1:0] REG_ONE_HIGH  = 2'd2;
  localparam logic [1:0] REG_ONE_LOW   = 2'd3;
  localparam int         PADDR_W       = 4;
  localparam int         PDATA_W       = 32;

  // Register reset values.
  localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 15'd12;
  localparam logic [TICK_W-1:0] RST_ZERO_LOW  = 15'd21;
  localparam logic [TICK_W-1:0] RST_ONE_HIGH  = 15'd25;
  localparam logic [TICK_W-1:0] RST_ONE_LOW   = 15'd8;

  // Pulse timings as held by the register block.
  typedef struct packed {
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] zero_low;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] one_low;
  } ticks_t;

  // Handshake between the lane pipeline and the serialiser.
  typedef struct packed {
    logic valid;
    logic take;
  } load_ctl_t;

  // Builds the 16-bit frame: value, clear telemetry bit, then checksum.
  function automatic logic [FRAME_W-1:0] build_frame(input logic [VALUE_W-1:0] value);
    logic [11:0] word;
    logic [3:0]  crc;
    word = {value, 1'b0};
    crc  = word[3:0] ^ word[7:4] ^ word[11:8];
    return {word, crc};
  endfunction

endpackage

// ----- hdl/dfe_if.sv -----
// Item channel interfaces for the DShot frame encoder.
// Depends on dfe_pkg for field widths.
interface dfe_in_if;
  logic                           valid;
  logic                           ready;
  logic [dfe_pkg::US_W-1:0]       motor_a_us;
  logic [dfe_pkg::US_W-1:0]       motor_b_us;
  logic [dfe_pkg::US_W-1:0]       motor_c_us;
  logic [dfe_pkg::US_W-1:0]       motor_d_us;

  modport source (output valid, motor_a_us, motor_b_us, motor_c_us, motor_d_us,
                  input ready);
  modport sink (input valid, motor_a_us, motor_b_us, motor_c_us, motor_d_us,
                output ready);
endinterface

interface dfe_out_if;
  logic                           valid;
  logic                           ready;
  logic [dfe_pkg::CH_W-1:0]       channel;
  logic [dfe_pkg::BIT_W-1:0]      bit_index;
  logic                           bit_value;
  logic [dfe_pkg::TICK_W-1:0]     high_ticks;
  logic [dfe_pkg::TICK_W-1:0]     low_ticks;
  logic                           last;

  modport source (output valid, channel, bit_index, bit_value, high_ticks, low_ticks,
                  last, input ready);
  modport sink (input valid, channel, bit_index, bit_value, high_ticks, low_ticks,
                last, output ready);
endinterface

// ----- hdl/dfe_cfg.sv -----
// APB-style register block holding the four pulse timings.
// Depends on dfe_pkg for the register map and reset values.
module dfe_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dfe_pkg::PADDR_W-1:0]   paddr,
  input  logic [dfe_pkg::PDATA_W-1:0]   pwdata,
  output logic [dfe_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output dfe_pkg::ticks_t               ticks
);

  dfe_pkg::ticks_t ticks_r, ticks_nxt;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign ticks   = ticks_r;

  // Write decode: only the low 15 bits of the data are kept.
  always_comb begin
    ticks_nxt = ticks_r;
    if (wr_en) begin
      unique case (reg_idx)
        dfe_pkg::REG_ZERO_HIGH: ticks_nxt.zero_high = pwdata[dfe_pkg::TICK_W-1:0];
        dfe_pkg::REG_ZERO_LOW:  ticks_nxt.zero_low  = pwdata[dfe_pkg::TICK_W-1:0];
        dfe_pkg::REG_ONE_HIGH:  ticks_nxt.one_high  = pwdata[dfe_pkg::TICK_W-1:0];
        dfe_pkg::REG_ONE_LOW:   ticks_nxt.one_low   = pwdata[dfe_pkg::TICK_W-1:0];
        default:                ticks_nxt = ticks_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r.zero_high <= dfe_pkg::RST_ZERO_HIGH;
      ticks_r.zero_low  <= dfe_pkg::RST_ZERO_LOW;
      ticks_r.one_high  <= dfe_pkg::RST_ONE_HIGH;
      ticks_r.one_low   <= dfe_pkg::RST_ONE_LOW;
    end else begin
      ticks_r <= ticks_nxt;
    end
  end

  // Read decode.
  always_comb begin
    unique case (reg_idx)
      dfe_pkg::REG_ZERO_HIGH: prdata = dfe_pkg::PDATA_W'(ticks_r.zero_high);
      dfe_pkg::REG_ZERO_LOW:  prdata = dfe_pkg::PDATA_W'(ticks_r.zero_low);
      dfe_pkg::REG_ONE_HIGH:  prdata = dfe_pkg::PDATA_W'(ticks_r.one_high);
      dfe_pkg::REG_ONE_LOW:   prdata = dfe_pkg::PDATA_W'(ticks_r.one_low);
      default:                prdata = '0;
    endcase
  end

endmodule

// ----- hdl/dfe_lane.sv -----
// One channel lane: maps a throttle command to a 16-bit DShot frame.
// Two register stages, one multiplier each. Depends on dfe_pkg.
module dfe_lane (
  input  logic                          clk,
  input  logic                          en1,
  input  logic                          en2,
  input  logic [dfe_pkg::US_W-1:0]      throttle_us,
  output logic [dfe_pkg::FRAME_W-1:0]   frame
);

  logic [dfe_pkg::US_W-1:0]         span;
  logic                             idle_r, idle_nxt;
  logic [dfe_pkg::PROD_W-1:0]       prod_r, prod_nxt;
  logic [dfe_pkg::PROD_W+dfe_pkg::RECIP_W-1:0] scaled;
  logic [dfe_pkg::QUOT_W-1:0]       quot;
  logic [dfe_pkg::QUOT_W:0]         mapped;
  logic [dfe_pkg::VALUE_W-1:0]      value;
  logic [dfe_pkg::FRAME_W-1:0]      frame_r, frame_nxt;

  // Stage 1: offset and scale by 1999.
  always_comb begin
    idle_nxt = (throttle_us <= dfe_pkg::US_IDLE);
    span     = throttle_us - dfe_pkg::US_BASE;
    prod_nxt = dfe_pkg::PROD_W'(span) * dfe_pkg::PROD_W'(dfe_pkg::SPAN_MUL);
  end

  // Stage 2: divide by 999 through the scaled reciprocal, offset and saturate.
  always_comb begin
    scaled = (dfe_pkg::PROD_W + dfe_pkg::RECIP_W)'(prod_r)
           * (dfe_pkg::PROD_W + dfe_pkg::RECIP_W)'(dfe_pkg::RECIP_999);
    quot   = scaled[dfe_pkg::RECIP_SHIFT +: dfe_pkg::QUOT_W];
    mapped = {1'b0, quot} + (dfe_pkg::QUOT_W + 1)'(dfe_pkg::VALUE_MIN);
    if (idle_r) begin
      value = '0;
    end else if (mapped > (dfe_pkg::QUOT_W + 1)'(dfe_pkg::VALUE_MAX)) begin
      value = dfe_pkg::VALUE_MAX;
    end else begin
      value = mapped[dfe_pkg::VALUE_W-1:0];
    end
    frame_nxt = dfe_pkg::build_frame(value);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      idle_r <= idle_nxt;
      prod_r <= prod_nxt;
    end
    if (en2) begin
      frame_r <= frame_nxt;
    end
  end

  assign frame = frame_r;

endmodule

// ----- hdl/dfe_serializer.sv -----
// Merging stage: takes all lane frames and sends one symbol item per cycle
// while ready is high, channel by channel, MSB first. Depends on dfe_pkg.
module dfe_serializer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load_valid,
  input  logic [dfe_pkg::SER_W-1:0]     frames,
  input  dfe_pkg::ticks_t               ticks,
  output dfe_pkg::load_ctl_t            ctl,
  dfe_out_if.source                     out_ch
);

  logic [dfe_pkg::SER_W-1:0]  shift_r, shift_nxt;
  logic [dfe_pkg::CH_W-1:0]   ch_r, ch_nxt;
  logic [dfe_pkg::BIT_W-1:0]  bit_r, bit_nxt;
  logic                       busy_r, busy_nxt;
  logic                       fire, at_end, take;

  assign fire   = busy_r && out_ch.ready;
  assign at_end = (ch_r == dfe_pkg::CH_W'(dfe_pkg::CHANNELS - 1))
               && (bit_r == {dfe_pkg::BIT_W{1'b1}});
  assign take   = load_valid && (!busy_r || (fire && at_end));

  assign ctl.valid = busy_r;
  assign ctl.take  = take;

  // Symbol sequencing.
  always_comb begin
    shift_nxt = shift_r;
    ch_nxt    = ch_r;
    bit_nxt   = bit_r;
    busy_nxt  = busy_r;
    if (take) begin
      shift_nxt = frames;
      ch_nxt    = '0;
      bit_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (fire) begin
      shift_nxt = {shift_r[dfe_pkg::SER_W-2:0], 1'b0};
      bit_nxt   = bit_r + 1'b1;
      if (bit_r == {dfe_pkg::BIT_W{1'b1}}) begin
        ch_nxt = ch_r + 1'b1;
      end
      if (at_end) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ch_r   <= '0;
      bit_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ch_r   <= ch_nxt;
      bit_r  <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  // Symbol item fields.
  assign out_ch.valid      = busy_r;
  assign out_ch.channel    = ch_r;
  assign out_ch.bit_index  = bit_r;
  assign out_ch.bit_value  = shift_r[dfe_pkg::SER_W-1];
  assign out_ch.high_ticks = shift_r[dfe_pkg::SER_W-1] ? ticks.one_high : ticks.zero_high;
  assign out_ch.low_ticks  = shift_r[dfe_pkg::SER_W-1] ? ticks.one_low : ticks.zero_low;
  assign out_ch.last       = at_end;

endmodule

// ----- hdl/dshot_frame_encoder_top.sv -----
// DShot frame encoder, four motor channels.
// Input channel in_ch: one item carries four throttle commands in microseconds.
// Output channel out_ch: one item per pulse symbol, 16 per channel, channel 0
// first and most significant bit first; last marks the final symbol of channel 3.
// Configuration port: APB-style, four 15-bit timing registers at byte addresses
// 0, 4, 8 and 12 (zero high, zero low, one high, one low); pready is always high.
// Four lanes compute the frames in parallel through two register stages, and
// the serialiser then sends one symbol per cycle while out_ch.ready is high.
// An accepted item passes lane stage 1, lane stage 2 and the serialiser load
// before its first symbol is valid.
// The serialiser sends the 64 symbols of an item one a cycle while the receiver is ready.
// The lane stages hold up to two further items while a frame set is being sent,
// so input items are accepted while earlier symbols are still going out.
// When the receiver holds ready low the current symbol is held and nothing is
// lost; the lanes fill and then in_ch.ready drops.
// Reset (synchronous, active low) empties the pipeline and restores the timing
// registers to 12, 21, 25 and 8 ticks.
// Depends on dfe_pkg, dfe_if, dfe_cfg, dfe_lane, dfe_serializer and the defines header.
`include "dshot_frame_encoder_top_defines.svh"

module dshot_frame_encoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  dfe_in_if.sink                        in_ch,
  dfe_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dfe_pkg::PADDR_W-1:0]   paddr,
  input  logic [dfe_pkg::PDATA_W-1:0]   pwdata,
  output logic [dfe_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  dfe_pkg::ticks_t             ticks;
  dfe_pkg::load_ctl_t          ser_ctl;
  logic [dfe_pkg::US_W-1:0]    cmd [4];
  logic [dfe_pkg::SER_W-1:0]   frames;
  logic                        s1_valid_r, s1_valid_nxt;
  logic                        s2_valid_r, s2_valid_nxt;
  logic                        en1, en2, s1_ready, s2_ready;

  // Timing registers.
  dfe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ticks   (ticks)
  );

  // Lane pipeline flow control.
  assign s2_ready    = !s2_valid_r || ser_ctl.take;
  assign en2         = s1_valid_r && s2_ready;
  assign s1_ready    = !s1_valid_r || en2;
  assign en1         = in_ch.valid && s1_ready;
  assign in_ch.ready = s1_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s2_valid_nxt = s2_valid_r;
    if (en1) begin
      s1_valid_nxt = 1'b1;
    end else if (en2) begin
      s1_valid_nxt = 1'b0;
    end
    if (en2) begin
      s2_valid_nxt = 1'b1;
    end else if (ser_ctl.take) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // One lane per channel; channel 0 lands in the top frame of the word.
  assign cmd[0] = in_ch.motor_a_us;
  assign cmd[1] = in_ch.motor_b_us;
  assign cmd[2] = in_ch.motor_c_us;
  assign cmd[3] = in_ch.motor_d_us;

  for (genvar g = 0; g < dfe_pkg::CHANNELS; g++) begin : g_lane
    dfe_lane u_lane (
      .clk         (clk),
      .en1         (en1),
      .en2         (en2),
      .throttle_us (cmd[g]),
      .frame       (frames[dfe_pkg::SER_W - 1 - g*dfe_pkg::FRAME_W -: dfe_pkg::FRAME_W])
    );
  end

  // Merging stage and output.
  dfe_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s2_valid_r),
    .frames     (frames),
    .ticks      (ticks),
    .ctl        (ser_ctl),
    .out_ch     (out_ch)
  );

  // A frame set is sent without gaps until its last symbol.
  `DFE_ASSERT(a_no_gap_in_set, out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid)
  // Symbols within a frame set advance by one position at a time.
  `DFE_ASSERT(a_bit_step,
    out_ch.valid && out_ch.ready && !out_ch.last |=>
    out_ch.bit_index == dfe_pkg::BIT_W'($past(out_ch.bit_index) + 1'b1))
  // Finished frames wait in the lane stage until the serialiser takes them.
  `DFE_ASSERT(a_frames_held, s2_valid_r && !ser_ctl.take |=> s2_valid_r)
  // The input side only stalls when the first lane stage is occupied.
  `DFE_ASSERT_ALWAYS(a_stall_cause, !in_ch.ready |-> s1_valid_r)

endmodule
